// File: design/format_string_number_formatter_unit_assert.svh
// Assertion macros shared by the formatter RTL.
// Depends on nothing; each macro takes the clock and active-low reset names.
`ifndef FORMAT_STRING_NUMBER_FORMATTER_UNIT_ASSERT_SVH
`define FORMAT_STRING_NUMBER_FORMATTER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FFSN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ffsn assertion failed");

// antecedent implies consequent in the next cycle
`define FFSN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ffsn assertion failed");

`endif

// File: design/ffsn_pkg.sv
// Shared types and constants for the format string number formatter.
// Used by ffsn_front, ffsn_queue, ffsn_back and the top level; no dependencies.
package ffsn_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_LX      = 8'h78;
    localparam logic [7:0] CH_UX      = 8'h58;
    localparam logic [7:0] CH_P       = 8'h70;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_UA      = 8'h41;

    // floor(v / 10) = (v * DIV10_MAGIC) >> DIV10_SHIFT for any 32-bit v
    localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    // worst case: 16 hex digits of a 64-bit pointer
    localparam int DIG_DEPTH = 16;
    localparam int DIG_IDX_W = 4;
    localparam int DIG_CNT_W = 5;

    typedef enum logic [1:0] {
        OP_CHAR,
        OP_DEC,
        OP_HEX
    } op_t;

    typedef struct packed {
        op_t         op;
        logic        upper;
        logic        neg;
        logic        ptr;
        logic [63:0] value;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEN,
        ST_PRE,
        ST_CHAR,
        ST_DIG
    } state_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        if (d < 4'd10)
        begin
            base = CH_ZERO;
        end
        else
        begin
            base = (upper ? CH_UA : CH_LA) - 8'd10;
        end
        return base + {4'b0000, d};
    endfunction

endpackage

// File: design/ffsn_front.sv
// Front end: tracks the conversion flag and turns each format character
// into a command for the back end. Depends on ffsn_pkg.
`include "format_string_number_formatter_unit_assert.svh"

module ffsn_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        fmt_char,
    input  logic [63:0]       arg_value,
    input  logic              q_full,
    output logic              q_push,
    output ffsn_pkg::cmd_t    q_cmd
);

    logic        after_percent_reg;
    logic        after_percent_next;
    logic        has_cmd;
    logic        accept;
    logic [31:0] low32;

    assign low32    = arg_value[31:0];
    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && has_cmd;

    always_comb
    begin
        after_percent_next = after_percent_reg;
        has_cmd            = 1'b0;
        q_cmd.op           = ffsn_pkg::OP_CHAR;
        q_cmd.upper        = 1'b0;
        q_cmd.neg          = 1'b0;
        q_cmd.ptr          = 1'b0;
        q_cmd.value        = {56'd0, fmt_char};
        if (!after_percent_reg)
        begin
            if (fmt_char == ffsn_pkg::CH_PERCENT)
            begin
                after_percent_next = 1'b1;
            end
            else
            begin
                has_cmd = 1'b1;
            end
        end
        else
        begin
            after_percent_next = 1'b0;
            case (fmt_char)
                ffsn_pkg::CH_PERCENT:
                begin
                    has_cmd = 1'b1;
                end
                ffsn_pkg::CH_C:
                begin
                    has_cmd     = 1'b1;
                    q_cmd.value = {56'd0, arg_value[7:0]};
                end
                ffsn_pkg::CH_D, ffsn_pkg::CH_I:
                begin
                    has_cmd     = 1'b1;
                    q_cmd.op    = ffsn_pkg::OP_DEC;
                    q_cmd.neg   = low32[31];
                    // magnitude; 0x80000000 stays as 2147483648 unsigned
                    q_cmd.value = {32'd0, low32[31] ? (32'd0 - low32) : low32};
                end
                ffsn_pkg::CH_U:
                begin
                    has_cmd     = 1'b1;
                    q_cmd.op    = ffsn_pkg::OP_DEC;
                    q_cmd.value = {32'd0, low32};
                end
                ffsn_pkg::CH_LX:
                begin
                    has_cmd     = 1'b1;
                    q_cmd.op    = ffsn_pkg::OP_HEX;
                    q_cmd.value = {32'd0, low32};
                end
                ffsn_pkg::CH_UX:
                begin
                    has_cmd     = 1'b1;
                    q_cmd.op    = ffsn_pkg::OP_HEX;
                    q_cmd.upper = 1'b1;
                    q_cmd.value = {32'd0, low32};
                end
                ffsn_pkg::CH_P:
                begin
                    has_cmd     = 1'b1;
                    q_cmd.op    = ffsn_pkg::OP_HEX;
                    q_cmd.ptr   = 1'b1;
                    q_cmd.value = arg_value;
                end
                default:
                begin
                    has_cmd = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_percent_reg <= 1'b0;
        end
        else if (accept)
        begin
            after_percent_reg <= after_percent_next;
        end
    end

    `FFSN_ASSERT_NEXT(a_pct_arms, clk, rst_n,
        accept && !after_percent_reg && fmt_char == ffsn_pkg::CH_PERCENT, after_percent_reg)
    `FFSN_ASSERT_NEXT(a_conv_clears, clk, rst_n, accept && after_percent_reg, !after_percent_reg)
    `FFSN_ASSERT_NOW(a_pct_no_cmd, clk, rst_n,
        !after_percent_reg && fmt_char == ffsn_pkg::CH_PERCENT, !q_push)

endmodule

// File: design/ffsn_queue.sv
// Short command queue between front and back ends.
// Depends on ffsn_pkg for the command type.
`include "format_string_number_formatter_unit_assert.svh"

module ffsn_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ffsn_pkg::cmd_t    push_cmd,
    output logic              full,
    input  logic              pop,
    output ffsn_pkg::cmd_t    pop_cmd,
    output logic              empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ffsn_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `FFSN_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full)
    `FFSN_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, !empty)
    `FFSN_ASSERT_NOW(a_count_range, clk, rst_n, 1'b1, count_reg <= CNT_FULL)

endmodule

// File: design/ffsn_back.sv
// Back end: generates digits one per cycle into a small stack, then emits
// the prefix and the digits most significant first. Depends on ffsn_pkg.
`include "format_string_number_formatter_unit_assert.svh"

module ffsn_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  ffsn_pkg::cmd_t    q_cmd,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_char,
    output logic              last_char
);

    ffsn_pkg::state_t state_reg;
    ffsn_pkg::state_t state_next;
    ffsn_pkg::cmd_t   cmd_reg;

    logic [3:0]                   stack_reg [ffsn_pkg::DIG_DEPTH];
    logic [ffsn_pkg::DIG_CNT_W-1:0] k_reg;
    logic                         pre_pos_reg;

    logic        out_valid_reg;
    logic [7:0]  out_char_reg;
    logic        last_reg;

    logic        can_emit;
    logic        emit;
    logic [7:0]  emit_char;
    logic        emit_last;
    logic [3:0]  gen_digit;
    logic [63:0] gen_value_next;
    logic        gen_done;
    logic [63:0] div_prod;
    logic [31:0] div_q;
    logic [31:0] div_q10;
    logic [ffsn_pkg::DIG_IDX_W-1:0] top_idx;

    assign can_emit  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_reg;
    assign top_idx   = ffsn_pkg::DIG_IDX_W'(k_reg - 1'b1);

    // one digit step: divide by ten via reciprocal, or take a nibble
    always_comb
    begin
        div_prod = {32'd0, cmd_reg.value[31:0]} * {32'd0, ffsn_pkg::DIV10_MAGIC};
        div_q    = 32'(div_prod[63:ffsn_pkg::DIV10_SHIFT]);
        div_q10  = {div_q[28:0], 3'b000} + {div_q[30:0], 1'b0};
        if (cmd_reg.op == ffsn_pkg::OP_DEC)
        begin
            gen_digit      = 4'(cmd_reg.value[31:0] - div_q10);
            gen_value_next = {32'd0, div_q};
        end
        else
        begin
            gen_digit      = cmd_reg.value[3:0];
            gen_value_next = {4'd0, cmd_reg.value[63:4]};
        end
        gen_done = (gen_value_next == 64'd0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ffsn_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (q_cmd.op == ffsn_pkg::OP_CHAR) ?
                                 ffsn_pkg::ST_CHAR : ffsn_pkg::ST_GEN;
                end
            end
            ffsn_pkg::ST_GEN:
            begin
                if (gen_done)
                begin
                    state_next = (cmd_reg.neg || cmd_reg.ptr) ?
                                 ffsn_pkg::ST_PRE : ffsn_pkg::ST_DIG;
                end
            end
            ffsn_pkg::ST_PRE:
            begin
                if (can_emit && !(cmd_reg.ptr && !pre_pos_reg))
                begin
                    state_next = ffsn_pkg::ST_DIG;
                end
            end
            ffsn_pkg::ST_CHAR:
            begin
                if (can_emit)
                begin
                    state_next = ffsn_pkg::ST_IDLE;
                end
            end
            ffsn_pkg::ST_DIG:
            begin
                if (can_emit && k_reg == ffsn_pkg::DIG_CNT_W'(1))
                begin
                    state_next = ffsn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ffsn_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        q_pop     = 1'b0;
        emit      = 1'b0;
        emit_char = cmd_reg.value[7:0];
        emit_last = 1'b0;
        case (state_reg)
            ffsn_pkg::ST_IDLE:
            begin
                q_pop = !q_empty;
            end
            ffsn_pkg::ST_PRE:
            begin
                emit = can_emit;
                if (cmd_reg.ptr)
                begin
                    emit_char = pre_pos_reg ? ffsn_pkg::CH_LX : ffsn_pkg::CH_ZERO;
                end
                else
                begin
                    emit_char = ffsn_pkg::CH_MINUS;
                end
            end
            ffsn_pkg::ST_CHAR:
            begin
                emit      = can_emit;
                emit_last = 1'b1;
            end
            ffsn_pkg::ST_DIG:
            begin
                emit      = can_emit;
                emit_char = ffsn_pkg::digit_char(stack_reg[top_idx], cmd_reg.upper);
                emit_last = (k_reg == ffsn_pkg::DIG_CNT_W'(1));
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ffsn_pkg::ST_IDLE && !q_empty)
        begin
            cmd_reg <= q_cmd;
        end
        else if (state_reg == ffsn_pkg::ST_GEN)
        begin
            cmd_reg.value <= gen_value_next;
        end
        if (state_reg == ffsn_pkg::ST_GEN)
        begin
            stack_reg[k_reg[ffsn_pkg::DIG_IDX_W-1:0]] <= gen_digit;
        end
        if (emit)
        begin
            out_char_reg <= emit_char;
            last_reg     <= emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffsn_pkg::ST_IDLE;
            k_reg         <= '0;
            pre_pos_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ffsn_pkg::ST_IDLE:
                begin
                    k_reg       <= '0;
                    pre_pos_reg <= 1'b0;
                end
                ffsn_pkg::ST_GEN:
                begin
                    k_reg <= k_reg + 1'b1;
                end
                ffsn_pkg::ST_PRE:
                begin
                    if (can_emit)
                    begin
                        pre_pos_reg <= 1'b1;
                    end
                end
                ffsn_pkg::ST_DIG:
                begin
                    if (can_emit)
                    begin
                        k_reg <= k_reg - 1'b1;
                    end
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    `FFSN_ASSERT_NOW(a_stack_bound, clk, rst_n,
        state_reg == ffsn_pkg::ST_GEN, k_reg < ffsn_pkg::DIG_CNT_W'(ffsn_pkg::DIG_DEPTH))
    `FFSN_ASSERT_NOW(a_dig_nonempty, clk, rst_n,
        state_reg == ffsn_pkg::ST_DIG || state_reg == ffsn_pkg::ST_PRE, k_reg != '0)
    `FFSN_ASSERT_NOW(a_no_emit_busy, clk, rst_n,
        state_reg == ffsn_pkg::ST_IDLE || state_reg == ffsn_pkg::ST_GEN, !emit)

endmodule

// File: design/format_string_number_formatter_unit.sv
// Streaming printf-subset formatter: input channel carries one format
// character (fmt_char) with its argument (arg_value); output channel carries
// one character (out_char) with last_char on the final character of each
// input's output run. Both channels use valid/ready.
// Ordinary characters are echoed; '%' produces nothing; the next character
// selects %, c, d/i, u, x, X or p; unknown conversions produce nothing.
// A front end classifies inputs into a QUEUE_DEPTH-entry command queue; a
// back end formats one command at a time through a registered output.
// A single-character result passes through the queue, the back-end command
// register and the output register. Numbers first generate their digits
// (one divide-by-ten or nibble step per cycle), then emit the prefix and
// digit characters one at a time as the output register frees up.
// The back-end digit loop sets the rate; the front end takes a new item
// each cycle while the queue has room.
// Reset clears the conversion flag, the queue and the output register.
// When the receiver stalls, the output holds, the back end waits, and
// the input stalls once the queue fills.
module format_string_number_formatter_unit
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  fmt_char,
    input  logic [63:0] arg_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_char,
    output logic        last_char
);

    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    ffsn_pkg::cmd_t push_cmd;
    ffsn_pkg::cmd_t pop_cmd;

    ffsn_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .fmt_char  (fmt_char),
        .arg_value (arg_value),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    ffsn_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    ffsn_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_cmd     (pop_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last_char (last_char)
    );

endmodule

// File: test/ffsn_text_checker.sv
// Checker for the format string formatter: watches the input and output channels,
// predicts the emitted text and compares it character by character.
// Depends on ffsn_pkg for the format character codes.
module ffsn_text_checker
    import ffsn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  fmt_char,
    input  logic [63:0] arg_value,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_char,
    input  logic        last_char,
    output int          mismatch_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    text_char_t expected_text[$];
    logic [7:0] run_chars[$];
    logic       in_conversion;

    // digits of v in the given radix, most significant first, no leading zeros
    task automatic append_digits(input logic [63:0] v, input int radix, input logic upper);
        logic [7:0] digits[$];
        logic [3:0] d;
        do
        begin
            d = 4'(v % radix);
            if (d < 4'd10)
            begin
                digits.push_front(CH_ZERO + 8'(d));
            end
            else
            begin
                digits.push_front((upper ? CH_UA : CH_LA) + 8'(d) - 8'd10);
            end
            v = v / radix;
        end
        while (v != 64'd0);
        foreach (digits[i])
        begin
            run_chars.push_back(digits[i]);
        end
    endtask

    task automatic format_request(input logic [7:0] c, input logic [63:0] arg);
        logic [31:0] low32;
        low32 = arg[31:0];
        run_chars.delete();
        if (!in_conversion)
        begin
            if (c == CH_PERCENT)
            begin
                in_conversion = 1'b1;
            end
            else
            begin
                run_chars.push_back(c);
            end
        end
        else
        begin
            in_conversion = 1'b0;
            case (c)
                CH_PERCENT: run_chars.push_back(CH_PERCENT);
                CH_C:       run_chars.push_back(arg[7:0]);
                CH_D, CH_I:
                begin
                    if (low32[31])
                    begin
                        run_chars.push_back(CH_MINUS);
                        low32 = (~low32) + 32'd1;
                    end
                    append_digits({32'd0, low32}, 10, 1'b0);
                end
                CH_U:       append_digits({32'd0, low32}, 10, 1'b0);
                CH_LX:      append_digits({32'd0, low32}, 16, 1'b0);
                CH_UX:      append_digits({32'd0, low32}, 16, 1'b1);
                CH_P:
                begin
                    run_chars.push_back(CH_ZERO);
                    run_chars.push_back(CH_LX);
                    append_digits(arg, 16, 1'b0);
                end
                default:    ; // unknown conversion: no text
            endcase
        end
        foreach (run_chars[i])
        begin
            expected_text.push_back('{ch: run_chars[i], last: (i == run_chars.size() - 1)});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            in_conversion = 1'b0;
            expected_text.delete();
            mismatch_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_text.size() == 0)
                begin
                    $error("unexpected out_char 0x%02h last_char %0b", out_char, last_char);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_text.pop_front();
                    if (out_char !== want.ch)
                    begin
                        $error("out_char: expected 0x%02h, got 0x%02h", want.ch, out_char);
                        mismatch_count++;
                    end
                    if (last_char !== want.last)
                    begin
                        $error("last_char: expected %0b, got %0b", want.last, last_char);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                format_request(fmt_char, arg_value);
            end
            outstanding = expected_text.size();
        end
    end

endmodule

// File: test/testbench.sv
// Top of the formatter testbench: clock, reset, request stimulus and verdict.
// Depends on ffsn_pkg, format_string_number_formatter_unit and ffsn_text_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ffsn_pkg::*;

    // random part; the directed part adds about two dozen more
    localparam int RANDOM_ITEMS = 236;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 400;
    localparam logic [7:0] CH_S = 8'h73;   // unsupported string conversion

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  fmt_char;
    logic [63:0] arg_value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_char;
    logic        last_char;

    int mismatch_count;
    int outstanding;
    int results_taken;
    int cycle_count;
    bit sender_burst;

    format_string_number_formatter_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .fmt_char  (fmt_char),
        .arg_value (arg_value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_char  (out_char),
        .last_char (last_char)
    );

    ffsn_text_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .fmt_char       (fmt_char),
        .arg_value      (arg_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_char       (out_char),
        .last_char      (last_char),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_request(input logic [7:0] c, input logic [63:0] a);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        fmt_char  <= c;
        arg_value <= a;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_conversion(input logic [7:0] c, input logic [63:0] a);
        send_request(CH_PERCENT, {$urandom, $urandom});
        send_request(c, a);
    endtask

    // stop offering and wait until every predicted character has come out
    task automatic drain_text();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (outstanding != 0);
        @(posedge clk);
    endtask

    function automatic logic [63:0] random_arg();
        case ($urandom_range(0, 5))
            0:       return {$urandom, $urandom};
            1:       return {$urandom, 32'($urandom_range(0, 99))};
            2:       return 64'($urandom_range(0, 20));
            3:       return {$urandom, 32'h8000_0000};
            4:       return {$urandom, $urandom} >> $urandom_range(0, 63);
            default: return {32'd0, $urandom};
        endcase
    endfunction

    // receiver: random holds after each result, one long hold, one burst stretch
    initial
    begin
        int hold;
        out_ready = 1'b0;
        results_taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        out_ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_taken++;
                if (results_taken == 60)
                begin
                    hold = LONG_HOLD;
                end
                else if (results_taken >= 200 && results_taken < 350)
                begin
                    hold = 0;
                end
                else
                begin
                    hold = $urandom_range(0, 10);
                end
                if (hold > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (hold) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [7:0] conv_codes[8];
        logic [7:0] conv;
        int sent;
        bit mid_pause_done;

        conv_codes = '{CH_PERCENT, CH_C, CH_D, CH_I, CH_U, CH_LX, CH_UX, CH_P};
        rst_n = 1'b0;
        in_valid = 1'b0;
        fmt_char = 8'h00;
        arg_value = 64'd0;
        sender_burst = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: echo extremes, every conversion, edge values
        send_request(8'h41, 64'd0);
        send_request(8'h00, {64{1'b1}});
        send_request(8'hFF, 64'd0);
        send_conversion(CH_PERCENT, 64'd0);
        send_conversion(CH_C, {64{1'b1}});
        send_conversion(CH_D, 64'h1234_5678_8000_0000);
        send_conversion(CH_I, 64'h0000_0000_FFFF_FFFF);
        send_conversion(CH_D, 64'hFFFF_FFFF_7FFF_FFFF);
        send_conversion(CH_U, 64'h0000_0000_FFFF_FFFF);
        send_conversion(CH_LX, 64'hFFFF_FFFF_0000_0000);
        send_conversion(CH_UX, 64'h0000_0000_DEAD_BEEF);
        send_conversion(CH_P, {64{1'b1}});
        send_conversion(CH_P, 64'd0);
        send_conversion(CH_S, 64'h0000_0000_0000_0041);
        drain_text();

        sent = 0;
        mid_pause_done = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            sender_burst = (sent >= 100 && sent < 140);
            if (!mid_pause_done && sent >= 170)
            begin
                drain_text();
                mid_pause_done = 1'b1;
            end
            if ($urandom_range(0, 9) < 6)
            begin
                if ($urandom_range(0, 8) == 0)
                begin
                    // mostly unknown conversion characters
                    send_conversion(8'($urandom_range(0, 255)), random_arg());
                    sent += 2;
                end
                else
                begin
                    conv = conv_codes[$urandom_range(0, 7)];
                    send_conversion(conv, random_arg());
                    sent += 2;
                end
            end
            else
            begin
                send_request(8'($urandom_range(0, 255)), random_arg());
                sent++;
            end
        end

        drain_text();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: format_string_number_formatter_unit.f
+incdir+design
design/ffsn_pkg.sv
design/ffsn_front.sv
design/ffsn_queue.sv
design/ffsn_back.sv
design/format_string_number_formatter_unit.sv
test/ffsn_text_checker.sv
test/testbench.sv
